[rtl/core/crcfd_pkg.sv]
// ----------------------------------------------------------------------------
// crcfd_pkg: shared types, constants and functions of the frame deframer
// Holds the result word layout, the CRC-16 byte step and the command decode.
// ----------------------------------------------------------------------------
package crcfd_pkg;

    // width of the stored payload length, received field is masked to it
    localparam int LENGTH_BITS = 16;
    // byte position counter must reach header + payload + one crc byte
    localparam int POS_W = LENGTH_BITS + 1;

    localparam int          HEADER_BYTES = 4;
    localparam logic [15:0] CRC_POLY     = 16'h1021;

    // function codes
    localparam logic [7:0] FN_SERVO_FIRST = 8'h01;
    localparam logic [7:0] FN_SERVO_LAST  = 8'h06;
    localparam logic [7:0] FN_SERVO_ALL   = 8'h07;
    localparam logic [7:0] FN_BEEPER      = 8'h08;

    // command classes
    localparam logic [1:0] CLASS_ONE_SERVO = 2'd0;
    localparam logic [1:0] CLASS_ALL_SERVO = 2'd1;
    localparam logic [1:0] CLASS_BEEPER    = 2'd2;
    localparam logic [1:0] CLASS_OTHER     = 2'd3;

    // one result word
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic [15:0] payload_index;
        logic        frame_end;
        logic        crc_ok;
        logic [7:0]  device_address;
        logic [7:0]  function_code;
        logic [15:0] payload_length;
        logic [1:0]  command_class;
    } crcfd_result_t;

    // fold one byte into the crc, msb first, no reflection
    function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // class of a function code
    function automatic logic [1:0] cmd_class_of(input logic [7:0] f);
        logic [1:0] r;
        if (f >= FN_SERVO_FIRST && f <= FN_SERVO_LAST)
            r = CLASS_ONE_SERVO;
        else if (f == FN_SERVO_ALL)
            r = CLASS_ALL_SERVO;
        else if (f == FN_BEEPER)
            r = CLASS_BEEPER;
        else
            r = CLASS_OTHER;
        return r;
    endfunction

endpackage

[rtl/core/crcfd_if.sv]
// ----------------------------------------------------------------------------
// crcfd_if: valid/ready channels of the frame deframer
// Byte channel towards the block and result channel out of it.
// ----------------------------------------------------------------------------
interface crcfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crcfd_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [15:0] payload_index;
    logic        frame_end;
    logic        crc_ok;
    logic [7:0]  device_address;
    logic [7:0]  function_code;
    logic [15:0] payload_length;
    logic [1:0]  command_class;

    modport source (
        output valid, output payload_byte, output payload_valid, output payload_index,
        output frame_end, output crc_ok, output device_address, output function_code,
        output payload_length, output command_class, input ready
    );
    modport sink (
        input valid, input payload_byte, input payload_valid, input payload_index,
        input frame_end, input crc_ok, input device_address, input function_code,
        input payload_length, input command_class, output ready
    );
endinterface

[rtl/core/crcfd_frame_ctrl.sv]
// ----------------------------------------------------------------------------
// crcfd_frame_ctrl: frame tracker and crc accumulator
// Decodes one byte against the frame position and updates the frame state.
// ----------------------------------------------------------------------------
module crcfd_frame_ctrl
    import crcfd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    rx_byte,
    output crcfd_result_t res
);

    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [15:0]            crc_reg, crc_next;
    logic [7:0]             addr_reg, addr_next;
    logic [7:0]             func_reg, func_next;
    logic [7:0]             crc_lo_reg, crc_lo_next;

    logic [POS_W-1:0]       crc_pos;
    logic                   in_header;
    logic                   in_payload;
    logic                   at_crc_lo;
    logic [15:0]            crc_base;
    logic [15:0]            crc_folded;
    logic [15:0]            len_hi_merge;
    logic [POS_W-1:0]       pay_offset;

    // frame section of the current byte
    assign crc_pos    = POS_W'(HEADER_BYTES) + POS_W'(len_reg);
    assign in_header  = pos_reg < POS_W'(HEADER_BYTES);
    assign in_payload = !in_header && (pos_reg < crc_pos);
    assign at_crc_lo  = !in_header && (pos_reg == crc_pos);
    assign pay_offset = pos_reg - POS_W'(HEADER_BYTES);

    // first byte of a frame restarts the crc
    assign crc_base     = (pos_reg == '0) ? 16'h0000 : crc_reg;
    assign crc_folded   = crc16_fold(crc_base, rx_byte);
    assign len_hi_merge = 16'(len_reg) | {rx_byte, 8'h00};

    // next state and result word
    always_comb
    begin
        pos_next    = pos_reg;
        len_next    = len_reg;
        crc_next    = crc_reg;
        addr_next   = addr_reg;
        func_next   = func_reg;
        crc_lo_next = crc_lo_reg;

        res = '0;

        if (in_header)
        begin
            case (pos_reg[1:0])
                2'd0:    addr_next = rx_byte;
                2'd1:    func_next = rx_byte;
                2'd2:    len_next  = LENGTH_BITS'(rx_byte);
                default: len_next  = len_hi_merge[LENGTH_BITS-1:0];
            endcase
            crc_next = crc_folded;
            pos_next = pos_reg + 1'b1;
        end
        else if (in_payload)
        begin
            res.payload_byte  = rx_byte;
            res.payload_valid = 1'b1;
            res.payload_index = 16'(pay_offset[LENGTH_BITS-1:0]);
            crc_next          = crc_folded;
            pos_next          = pos_reg + 1'b1;
        end
        else if (at_crc_lo)
        begin
            crc_lo_next = rx_byte;
            pos_next    = pos_reg + 1'b1;
        end
        else
        begin
            res.frame_end = 1'b1;
            res.crc_ok    = ({rx_byte, crc_lo_reg} == crc_reg);
            pos_next      = '0;
        end

        // header fields as they stand after this byte
        res.device_address = addr_next;
        res.function_code  = func_next;
        res.payload_length = 16'(len_next);
        res.command_class  = cmd_class_of(func_next);
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            len_reg    <= '0;
            crc_reg    <= '0;
            addr_reg   <= '0;
            func_reg   <= '0;
            crc_lo_reg <= '0;
        end
        else if (step)
        begin
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            crc_reg    <= crc_next;
            addr_reg   <= addr_next;
            func_reg   <= func_next;
            crc_lo_reg <= crc_lo_next;
        end
    end

endmodule

[rtl/core/crc_frame_deframer.sv]
// Path: an accepted byte goes to the input register, its result word to the result register.
// Throughput: one byte per cycle unless result.ready stalls; input register,
// frame tracker's single-byte crc step and result register keep that pace.
// Reset: rst_n clears the frame position, length, crc, header registers and
// both stage valid flags; the first byte after reset starts a new frame.
// ----------------------------------------------------------------------------
// crc_frame_deframer: length-prefixed frame deframer with crc-16 check
// Registers each byte, tracks the frame and registers one result per byte.
// ----------------------------------------------------------------------------
module crc_frame_deframer
    import crcfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    crcfd_byte_if.sink            rx,
    crcfd_result_if.source        result
);

    logic          s1_valid_reg;
    logic [7:0]    s1_byte_reg;
    logic          s2_valid_reg;
    crcfd_result_t s2_res_reg;

    logic          s2_free;
    logic          advance;
    crcfd_result_t res;

    // stage flow control
    assign s2_free  = !s2_valid_reg || result.ready;
    assign advance  = s1_valid_reg && s2_free;
    assign rx.ready = !s1_valid_reg || s2_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (rx.ready)
            s1_valid_reg <= rx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
            s1_byte_reg <= rx.rx_byte;
    end

    // frame tracking
    crcfd_frame_ctrl u_frame_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (s1_byte_reg),
        .res     (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_free)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            s2_res_reg <= res;
    end

    // result word to the port
    assign result.valid          = s2_valid_reg;
    assign result.payload_byte   = s2_res_reg.payload_byte;
    assign result.payload_valid  = s2_res_reg.payload_valid;
    assign result.payload_index  = s2_res_reg.payload_index;
    assign result.frame_end      = s2_res_reg.frame_end;
    assign result.crc_ok         = s2_res_reg.crc_ok;
    assign result.device_address = s2_res_reg.device_address;
    assign result.function_code  = s2_res_reg.function_code;
    assign result.payload_length = s2_res_reg.payload_length;
    assign result.command_class  = s2_res_reg.command_class;

endmodule
